// ===== rtl/core/nsc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// NMEA sentence checker package
// Shared types, character constants and helper functions.
// ----------------------------------------------------------------------------
package nsc_pkg;

    localparam logic [7:0] LINE_LIMIT   = 8'd255;
    localparam logic [3:0] KEYWORD_MAX  = 4'd8;

    localparam logic [7:0] CHAR_DOLLAR  = 8'h24;
    localparam logic [7:0] CHAR_STAR    = 8'h2A;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_LOW     = 8'd32;
    localparam logic [7:0] CHAR_HIGH    = 8'd126;

    localparam logic CFG_KEYWORD_BYTES  = 1'b0;
    localparam logic CFG_KEYWORD_LENGTH = 1'b1;

    typedef enum logic [1:0] {
        CLS_NEWLINE,
        CLS_PRINT,
        CLS_OTHER
    } t_class;

    typedef enum logic [2:0] {
        PH_WAIT_DOLLAR,
        PH_XOR,
        PH_HEX_HIGH,
        PH_HEX_LOW,
        PH_DONE
    } t_phase;

    typedef struct packed {
        logic [7:0] data;
        t_class     cls;
    } t_item;

    typedef struct packed {
        logic       sentence_accepted;
        logic       checksum_valid;
        logic       keyword_seen;
        logic [7:0] line_length;
        logic       line_truncated;
    } t_result;

    function automatic t_class classify(input logic [7:0] c);
        t_class k;
        if (c == CHAR_NEWLINE) begin
            k = CLS_NEWLINE;
        end else if (c >= CHAR_LOW && c <= CHAR_HIGH) begin
            k = CLS_PRINT;
        end else begin
            k = CLS_OTHER;
        end
        return k;
    endfunction

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] v;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = 4'(c - 8'h30);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = 4'(c - 8'h37);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = 4'(c - 8'h57);
        end else begin
            v = 4'd0;
        end
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/nsc_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// NMEA sentence checker front end
// Registers each received byte together with its character class.
// ----------------------------------------------------------------------------
module nsc_front (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              push,
    output logic             full,
    input  wire  [7:0]       i_rx_byte,
    output logic             o_valid,
    output nsc_pkg::t_item   o_item,
    input  wire              i_q_full
);
    import nsc_pkg::*;

    logic  r_valid;
    t_item r_item;
    logic  accept;

    assign full    = r_valid && i_q_full;
    assign accept  = push && !full;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (!i_q_full) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.data <= i_rx_byte;
            r_item.cls  <= classify(i_rx_byte);
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/nsc_itemq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// NMEA sentence checker item queue
// Two-entry queue of classified bytes between the front and back ends.
// ----------------------------------------------------------------------------
module nsc_itemq (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  nsc_pkg::t_item   i_item,
    output logic             o_full,
    input  wire              i_pop,
    output nsc_pkg::t_item   o_item,
    output logic             o_empty
);
    import nsc_pkg::*;

    t_item      r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    logic       do_push;
    logic       do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_item  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (do_push) begin
                r_wptr <= !r_wptr;
            end
            if (do_pop) begin
                r_rptr <= !r_rptr;
            end
            r_count <= r_count + 2'(do_push) - 2'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/nsc_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// NMEA sentence checker back end
// Tracks the checksum, keyword window and line length, and queues results.
// ----------------------------------------------------------------------------
module nsc_back (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire  [63:0]      i_keyword_bytes,
    input  wire  [3:0]       i_keyword_length,
    input  wire              i_item_valid,
    input  nsc_pkg::t_item   i_item,
    output logic             o_item_pop,
    output logic             empty,
    input  wire              pop,
    output nsc_pkg::t_result o_result
);
    import nsc_pkg::*;

    t_phase      r_phase;
    t_phase      n_phase;
    logic [7:0]  r_xor;
    logic [7:0]  n_xor;
    logic [7:0]  r_rcv;
    logic [7:0]  n_rcv;
    logic [7:0]  r_kept;
    logic [7:0]  n_kept;
    logic [63:0] r_recent;
    logic [63:0] n_recent;
    logic        r_hit;
    logic        n_hit;

    t_result     r_res [2];
    logic        r_wptr;
    logic        r_rptr;
    logic [1:0]  r_count;

    logic        work;
    logic        finish;
    logic        truncated;
    logic [3:0]  used_len;
    logic [7:0]  kept_inc;
    logic [63:0] recent_shift;
    logic [7:0]  byte_ok;
    logic        window_match;
    logic        sum_valid;
    logic        seen;
    t_result     res;
    logic        res_pop;

    assign work       = i_item_valid && (r_count != 2'd2);
    assign o_item_pop = work;
    assign used_len   = (i_keyword_length > KEYWORD_MAX) ? KEYWORD_MAX : i_keyword_length;
    assign kept_inc   = r_kept + 8'd1;
    assign recent_shift = {r_recent[55:0], i_item.data};

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            if (4'(i) >= used_len) begin
                byte_ok[i] = 1'b1;
            end else begin
                byte_ok[i] = recent_shift[8*i +: 8] ==
                             i_keyword_bytes[8*(3'(used_len - 4'd1 - 4'(i))) +: 8];
            end
        end
    end

    assign window_match = (kept_inc >= {4'd0, used_len}) && (&byte_ok);

    assign sum_valid = (r_phase == PH_HEX_HIGH || r_phase == PH_HEX_LOW ||
                        r_phase == PH_DONE) && (r_xor == r_rcv);
    assign seen      = r_hit || (used_len == 4'd0);

    always_comb begin
        n_phase   = r_phase;
        n_xor     = r_xor;
        n_rcv     = r_rcv;
        n_kept    = r_kept;
        n_recent  = r_recent;
        n_hit     = r_hit;
        finish    = 1'b0;
        truncated = 1'b0;
        if (work) begin
            if (i_item.cls == CLS_NEWLINE || r_kept >= LINE_LIMIT) begin
                finish    = 1'b1;
                truncated = (i_item.cls != CLS_NEWLINE);
                n_phase   = PH_WAIT_DOLLAR;
                n_xor     = 8'd0;
                n_rcv     = 8'd0;
                n_kept    = 8'd0;
                n_recent  = 64'd0;
                n_hit     = 1'b0;
            end else if (i_item.cls == CLS_PRINT) begin
                n_kept   = kept_inc;
                n_recent = recent_shift;
                if (window_match) begin
                    n_hit = 1'b1;
                end
                case (r_phase)
                    PH_WAIT_DOLLAR: begin
                        if (i_item.data == CHAR_DOLLAR) begin
                            n_phase = PH_XOR;
                        end
                    end
                    PH_XOR: begin
                        if (i_item.data == CHAR_STAR) begin
                            n_phase = PH_HEX_HIGH;
                        end else begin
                            n_xor = r_xor ^ i_item.data;
                        end
                    end
                    PH_HEX_HIGH: begin
                        n_rcv   = {hex_value(i_item.data), 4'd0};
                        n_phase = PH_HEX_LOW;
                    end
                    PH_HEX_LOW: begin
                        n_rcv   = {r_rcv[7:4], hex_value(i_item.data)};
                        n_phase = PH_DONE;
                    end
                    default: begin
                        n_phase = r_phase;
                    end
                endcase
            end
        end
    end

    always_comb begin
        res.sentence_accepted = sum_valid && seen;
        res.checksum_valid    = sum_valid;
        res.keyword_seen      = seen;
        res.line_length       = r_kept;
        res.line_truncated    = truncated;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_WAIT_DOLLAR;
            r_xor    <= 8'd0;
            r_rcv    <= 8'd0;
            r_kept   <= 8'd0;
            r_recent <= 64'd0;
            r_hit    <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_xor    <= n_xor;
            r_rcv    <= n_rcv;
            r_kept   <= n_kept;
            r_recent <= n_recent;
            r_hit    <= n_hit;
        end
    end

    assign empty    = (r_count == 2'd0);
    assign res_pop  = pop && !empty;
    assign o_result = r_res[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (finish) begin
                r_wptr <= !r_wptr;
            end
            if (res_pop) begin
                r_rptr <= !r_rptr;
            end
            r_count <= r_count + 2'(finish) - 2'(res_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_res[r_wptr] <= res;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/nmea_sentence_checker_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// NMEA sentence checker
// Checks received NMEA 0183 lines byte by byte and reports one status per line.
// ----------------------------------------------------------------------------
// Usage:
// Received serial bytes are written with push while full is low; one byte can
// be transferred on every clock cycle. Each byte that ends a line (a newline,
// or any byte arriving on a full line) produces one status result; all other
// bytes produce none.
// A status result is read with pop while empty is low. It becomes visible
// once the line engine has written it into the result queue.
// A front register classifies each byte, a two-entry queue carries it to the
// line engine, and a two-entry result queue holds finished statuses. When pop
// is held low, the line engine stops once two results are waiting, and full
// rises once three further bytes are held; no byte or result is lost.
// The user must write the keyword registers through i_cfg_we, i_cfg_idx and
// i_cfg_data only while no line status is outstanding; this is not enforced.
// Synchronous reset clears all queues, the line state and both registers.
// ----------------------------------------------------------------------------
module nmea_sentence_checker_top (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire         i_cfg_idx,
    input  wire  [63:0] i_cfg_data,
    input  wire         push,
    output logic        full,
    input  wire  [7:0]  i_rx_byte,
    output logic        empty,
    input  wire         pop,
    output logic        o_sentence_accepted,
    output logic        o_checksum_valid,
    output logic        o_keyword_seen,
    output logic [7:0]  o_line_length,
    output logic        o_line_truncated
);
    import nsc_pkg::*;

    logic [63:0] r_keyword_bytes;
    logic [3:0]  r_keyword_length;

    logic        front_valid;
    t_item       front_item;
    logic        q_full;
    logic        q_empty;
    t_item       q_item;
    logic        q_pop;
    t_result     result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keyword_bytes  <= 64'd0;
            r_keyword_length <= 4'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_KEYWORD_BYTES:  r_keyword_bytes  <= i_cfg_data;
                CFG_KEYWORD_LENGTH: r_keyword_length <= i_cfg_data[3:0];
                default:            r_keyword_bytes  <= r_keyword_bytes;
            endcase
        end
    end

    nsc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .push      (push),
        .full      (full),
        .i_rx_byte (i_rx_byte),
        .o_valid   (front_valid),
        .o_item    (front_item),
        .i_q_full  (q_full)
    );

    nsc_itemq u_itemq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_item  (front_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_item  (q_item),
        .o_empty (q_empty)
    );

    nsc_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_keyword_bytes  (r_keyword_bytes),
        .i_keyword_length (r_keyword_length),
        .i_item_valid     (!q_empty),
        .i_item           (q_item),
        .o_item_pop       (q_pop),
        .empty            (empty),
        .pop              (pop),
        .o_result         (result)
    );

    assign o_sentence_accepted = result.sentence_accepted;
    assign o_checksum_valid    = result.checksum_valid;
    assign o_keyword_seen      = result.keyword_seen;
    assign o_line_length       = result.line_length;
    assign o_line_truncated    = result.line_truncated;

endmodule
`default_nettype wire
